FILE: hdl/ujs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ujs_pkg: shared types and constants of the UTF-8 to JSON string escaper
// Holds the command item passed from the decoder to the character emitter,
// the emission kinds, the character constants and the hex digit function.
// ---------------------------------------------------------------------------
package ujs_pkg;

    // Input actions.
    localparam logic ACT_DATA = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // What follows the opening quote and the replacement run of a command.
    localparam logic [2:0] K_NONE = 3'd0;   // nothing
    localparam logic [2:0] K_CHAR = 3'd1;   // one plain character
    localparam logic [2:0] K_ESC  = 3'd2;   // backslash and one character
    localparam logic [2:0] K_U1   = 3'd3;   // one \uXXXX
    localparam logic [2:0] K_U2   = 3'd4;   // surrogate pair, two \uXXXX

    localparam logic [6:0] CH_QUOTE = 7'h22;
    localparam logic [6:0] CH_BSL   = 7'h5C;
    localparam logic [6:0] CH_U     = 7'h75;

    localparam logic [15:0] REPL_CODE  = 16'hFFFD;
    localparam logic [15:0] SURR_HI    = 16'hD800;
    localparam logic [15:0] SURR_LO    = 16'hDC00;
    localparam logic [20:0] PLANE1     = 21'h010000;
    localparam logic [20:0] CODE_MAX   = 21'h10FFFF;

    // Command queue geometry.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic        open;   // send the opening quote first
        logic [1:0]  nrep;   // number of \ufffd for dropped sequence bytes
        logic [2:0]  kind;   // final emission kind
        logic [6:0]  ch;     // character for K_CHAR and K_ESC
        logic [15:0] w0;     // first 16-bit unit
        logic [15:0] w1;     // second 16-bit unit of a surrogate pair
    } t_cmd;

    // Lowercase hex digit of a nibble.
    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] r;
        if (nib < 4'd10) begin
            r = 7'h30 + {3'b000, nib};
        end else begin
            r = 7'h57 + {3'b000, nib};
        end
        return r;
    endfunction

endpackage

FILE: hdl/ujs_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ujs_front: UTF-8 decoder and classifier
// Tracks the open multi-byte sequence and turns each accepted item into
// one command that describes every character the item produces.
// ---------------------------------------------------------------------------
module ujs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_action,
    input  logic [7:0]    i_data_byte,
    output logic          o_push,
    output ujs_pkg::t_cmd o_cmd
);

    logic        r_in_string, n_in_string;
    logic [1:0]  r_pend, n_pend;
    logic [2:0]  r_len, n_len;
    logic [20:0] r_acc, n_acc;

    logic        have_code;
    logic [20:0] code;
    logic        lead;
    logic [20:0] acc_sh;
    logic [2:0]  got;
    logic [19:0] off;
    ujs_pkg::t_cmd cmd;
    ujs_pkg::t_cmd ccmd;

    assign acc_sh = {r_acc[14:0], i_data_byte[5:0]};
    assign got    = {1'b0, r_pend} + 3'd1;
    assign off    = 20'(code - ujs_pkg::PLANE1);

    // Escaping of one decoded code point.
    always_comb begin
        ccmd      = '0;
        ccmd.kind = ujs_pkg::K_ESC;
        case (code)
            21'h22:  ccmd.ch = ujs_pkg::CH_QUOTE;
            21'h5C:  ccmd.ch = ujs_pkg::CH_BSL;
            21'h08:  ccmd.ch = 7'h62;
            21'h0C:  ccmd.ch = 7'h66;
            21'h0A:  ccmd.ch = 7'h6E;
            21'h0D:  ccmd.ch = 7'h72;
            21'h09:  ccmd.ch = 7'h74;
            default: begin
                if (code < 21'h20) begin
                    ccmd.kind = ujs_pkg::K_U1;
                    ccmd.w0   = code[15:0];
                end else if (code < 21'h80) begin
                    ccmd.kind = ujs_pkg::K_CHAR;
                    ccmd.ch   = code[6:0];
                end else if (code <= 21'h00FFFF) begin
                    ccmd.kind = ujs_pkg::K_U1;
                    ccmd.w0   = code[15:0];
                end else if (code <= ujs_pkg::CODE_MAX) begin
                    ccmd.kind = ujs_pkg::K_U2;
                    ccmd.w0   = ujs_pkg::SURR_HI | {6'b0, off[19:10]};
                    ccmd.w1   = ujs_pkg::SURR_LO | {6'b0, off[9:0]};
                end else begin
                    ccmd.kind = ujs_pkg::K_U1;
                    ccmd.w0   = ujs_pkg::REPL_CODE;
                end
            end
        endcase
    end

    always_comb begin
        n_in_string = r_in_string;
        n_pend      = r_pend;
        n_len       = r_len;
        n_acc       = r_acc;
        have_code   = 1'b0;
        code        = '0;
        lead        = 1'b0;
        cmd         = '0;
        cmd.open    = !r_in_string;
        if (i_action == ujs_pkg::ACT_END) begin
            cmd.nrep    = r_pend;
            cmd.kind    = ujs_pkg::K_CHAR;
            cmd.ch      = ujs_pkg::CH_QUOTE;
            n_in_string = 1'b0;
            n_pend      = '0;
            n_len       = '0;
            n_acc       = '0;
        end else begin
            n_in_string = 1'b1;
            lead        = 1'b1;
            if (r_pend != 2'd0) begin
                if (i_data_byte[7:6] == 2'b10) begin
                    lead  = 1'b0;
                    n_acc = acc_sh;
                    if (got >= r_len) begin
                        have_code = 1'b1;
                        code      = acc_sh;
                        n_pend    = '0;
                        n_len     = '0;
                        n_acc     = '0;
                    end else begin
                        n_pend = got[1:0];
                    end
                end else begin
                    // Broken sequence: one replacement per byte received.
                    cmd.nrep = r_pend;
                    n_pend   = '0;
                    n_len    = '0;
                    n_acc    = '0;
                end
            end
            if (lead) begin
                if (!i_data_byte[7]) begin
                    have_code = 1'b1;
                    code      = {13'b0, i_data_byte};
                end else if (i_data_byte[7:5] == 3'b110) begin
                    n_acc  = {16'b0, i_data_byte[4:0]};
                    n_pend = 2'd1;
                    n_len  = 3'd2;
                end else if (i_data_byte[7:4] == 4'b1110) begin
                    n_acc  = {17'b0, i_data_byte[3:0]};
                    n_pend = 2'd1;
                    n_len  = 3'd3;
                end else if (i_data_byte[7:3] == 5'b11110) begin
                    n_acc  = {18'b0, i_data_byte[2:0]};
                    n_pend = 2'd1;
                    n_len  = 3'd4;
                end else begin
                    cmd.kind = ujs_pkg::K_U1;
                    cmd.w0   = ujs_pkg::REPL_CODE;
                end
            end
            if (have_code) begin
                cmd.kind = ccmd.kind;
                cmd.ch   = ccmd.ch;
                cmd.w0   = ccmd.w0;
                cmd.w1   = ccmd.w1;
            end
        end
    end

    assign o_cmd  = cmd;
    assign o_push = i_accept &&
                    (cmd.open || (cmd.nrep != 2'd0) || (cmd.kind != ujs_pkg::K_NONE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_string <= 1'b0;
            r_pend      <= '0;
            r_len       <= '0;
            r_acc       <= '0;
        end else if (i_accept) begin
            r_in_string <= n_in_string;
            r_pend      <= n_pend;
            r_len       <= n_len;
            r_acc       <= n_acc;
        end
    end

endmodule

FILE: hdl/ujs_cmd_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ujs_cmd_queue: command queue between decoder and emitter
// A small first-in first-out buffer of commands with a visible head.
// ---------------------------------------------------------------------------
module ujs_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ujs_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_head_valid,
    output ujs_pkg::t_cmd o_head
);

    ujs_pkg::t_cmd            r_mem [ujs_pkg::QDEPTH];
    logic [ujs_pkg::QAW-1:0]  r_wp;
    logic [ujs_pkg::QAW-1:0]  r_rp;
    logic [ujs_pkg::QCW-1:0]  r_cnt;

    assign o_full       = (r_cnt == ujs_pkg::QCW'(ujs_pkg::QDEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/ujs_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ujs_back: character emitter
// Walks the head command one char per unstalled cycle into an output register.
// ---------------------------------------------------------------------------
module ujs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  ujs_pkg::t_cmd i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [6:0]    o_out_char,
    output logic          o_run_last
);

    localparam logic [1:0] PH_OPEN = 2'd0;
    localparam logic [1:0] PH_REP  = 2'd1;
    localparam logic [1:0] PH_FIN  = 2'd2;

    logic [1:0] r_ph, n_ph;
    logic [1:0] r_rep, n_rep;
    logic [2:0] r_sub, n_sub;
    logic       r_word, n_word;
    logic       r_valid;
    logic [6:0] r_char;
    logic       r_last;

    logic [1:0]  eff;
    logic [15:0] word;
    logic [6:0]  uchar;
    logic [6:0]  gen_char;
    logic        gen_last;
    logic        load;
    logic [1:0]  rep_nx;
    logic        fin_none;

    assign load     = i_head_valid && (!r_valid || !i_stall);
    assign rep_nx   = r_rep + 2'd1;
    assign fin_none = (i_head.kind == ujs_pkg::K_NONE);

    always_comb begin
        eff = r_ph;
        if (eff == PH_OPEN && !i_head.open) begin
            eff = PH_REP;
        end
        if (eff == PH_REP && r_rep == i_head.nrep) begin
            eff = PH_FIN;
        end
    end

    always_comb begin
        if (eff == PH_REP) begin
            word = ujs_pkg::REPL_CODE;
        end else if (r_word) begin
            word = i_head.w1;
        end else begin
            word = i_head.w0;
        end
    end

    // Characters of one \uXXXX unit.
    always_comb begin
        case (r_sub)
            3'd0:    uchar = ujs_pkg::CH_BSL;
            3'd1:    uchar = ujs_pkg::CH_U;
            3'd2:    uchar = ujs_pkg::hex_char(word[15:12]);
            3'd3:    uchar = ujs_pkg::hex_char(word[11:8]);
            3'd4:    uchar = ujs_pkg::hex_char(word[7:4]);
            default: uchar = ujs_pkg::hex_char(word[3:0]);
        endcase
    end

    always_comb begin
        n_ph     = eff;
        n_rep    = r_rep;
        n_sub    = r_sub + 3'd1;
        n_word   = r_word;
        gen_char = uchar;
        gen_last = 1'b0;
        case (eff)
            PH_OPEN: begin
                gen_char = ujs_pkg::CH_QUOTE;
                gen_last = (i_head.nrep == 2'd0) && fin_none;
                n_ph     = PH_REP;
                n_sub    = '0;
            end
            PH_REP: begin
                if (r_sub == 3'd5) begin
                    n_sub    = '0;
                    n_rep    = rep_nx;
                    gen_last = (rep_nx == i_head.nrep) && fin_none;
                end
            end
            default: begin
                case (i_head.kind)
                    ujs_pkg::K_CHAR: begin
                        gen_char = i_head.ch;
                        gen_last = 1'b1;
                    end
                    ujs_pkg::K_ESC: begin
                        gen_char = (r_sub == 3'd0) ? ujs_pkg::CH_BSL : i_head.ch;
                        gen_last = (r_sub != 3'd0);
                    end
                    ujs_pkg::K_U1: begin
                        gen_last = (r_sub == 3'd5);
                    end
                    ujs_pkg::K_U2: begin
                        if (r_sub == 3'd5) begin
                            gen_last = r_word;
                            n_word   = 1'b1;
                            n_sub    = '0;
                        end
                    end
                    default: begin
                        gen_char = '0;
                        gen_last = 1'b1;
                    end
                endcase
            end
        endcase
        if (gen_last) begin
            n_ph   = PH_OPEN;
            n_rep  = '0;
            n_sub  = '0;
            n_word = 1'b0;
        end
    end

    assign o_pop      = load && gen_last;
    assign o_valid    = r_valid;
    assign o_out_char = r_char;
    assign o_run_last = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph    <= PH_OPEN;
            r_rep   <= '0;
            r_sub   <= '0;
            r_word  <= 1'b0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_ph    <= n_ph;
            r_rep   <= n_rep;
            r_sub   <= n_sub;
            r_word  <= n_word;
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= gen_char;
            r_last <= gen_last;
        end
    end

endmodule

FILE: hdl/utf8_to_json_string_escaper.sv
// The first character of an item passes through the command queue and then the output
// register before it leaves the block.
// Throughput: one character per cycle, set by the emitter, while the result channel does
// not stall; an item emits 0 to 24 characters, six for a typical non-ASCII character.
// Reset: synchronous, active low; clears the decoder state, the queue and the output
// valid; afterwards the next data item starts a new string with an opening quote.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8_to_json_string_escaper: UTF-8 to ASCII JSON string escaper
// Decodes UTF-8 bytes and emits the quoted, escaped JSON string one
// character per result, with run_last marking the final character of
// each input item.
// ---------------------------------------------------------------------------
module utf8_to_json_string_escaper (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input item channel.
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_action,
    input  logic [7:0] i_data_byte,
    // Result channel.
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_out_char,
    output logic       o_run_last
);

    // The decoder updates its sequence state at every accepted item and
    // hands a single command to the queue. A command describes everything
    // the item produces: an optional opening quote, a run of replacement
    // escapes for a broken sequence, and one final emission. Items that
    // produce nothing (a lead byte, a middle continuation byte) push no
    // command at all.
    logic          accept;
    logic          push;
    logic          pop;
    logic          full;
    logic          head_valid;
    ujs_pkg::t_cmd cmd;
    ujs_pkg::t_cmd head;

    // The input side stalls only when the queue is full, so the decoder
    // keeps taking items while the emitter works through long escapes.
    assign o_stall = full;
    assign accept  = i_valid && !full;

    ujs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_action    (i_action),
        .i_data_byte (i_data_byte),
        .o_push      (push),
        .o_cmd       (cmd)
    );

    ujs_cmd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (cmd),
        .i_pop        (pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // The emitter walks the head command one character per cycle while the
    // result channel is not stalled, and retires it with the character that carries run_last.
    ujs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_char   (o_out_char),
        .o_run_last   (o_run_last)
    );

endmodule

FILE: bench/utf8_to_json_string_escaper_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8_to_json_string_escaper_tb: self-checking bench of the JSON escaper
// Feeds UTF-8 strings and end-of-string items through the input channel,
// predicts every escaped character of each item with a local decoder, and
// compares each character taken from the result channel in order. Both
// channels idle at random, with some stretches running at full rate.
// ---------------------------------------------------------------------------
module utf8_to_json_string_escaper_tb;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 380;
    localparam int MAX_CHARS      = 25;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } t_json_char;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       i_action    = ujs_pkg::ACT_DATA;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [6:0] o_out_char;
    logic       o_run_last;

    // Decoder state of the predictor.
    logic        str_open;
    logic [1:0]  seq_got;
    logic [2:0]  seq_len;
    logic [20:0] code_bits;

    t_json_char  expected_chars[$];
    logic [6:0]  item_chars[$];

    int  fail_count  = 0;
    int  items_sent  = 0;
    int  idle_cycles = 0;
    int  stall_left  = 0;
    bit  quiet       = 1'b0;

    utf8_to_json_string_escaper i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_char  (o_out_char),
        .o_run_last  (o_run_last)
    );

    always #5 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // ---------------------------------------------------------------------
    // Predictor of the escaped output.
    // ---------------------------------------------------------------------
    function automatic logic [6:0] hex_digit(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 7'h30 + {3'b000, nib};
        end
        return 7'h61 + {3'b000, nib} - 7'd10;
    endfunction

    function automatic void add_char(input logic [6:0] ch);
        if (item_chars.size() < MAX_CHARS) begin
            item_chars.push_back(ch);
        end
    endfunction

    function automatic void add_unit(input logic [15:0] v);
        add_char(ujs_pkg::CH_BSL);
        add_char(ujs_pkg::CH_U);
        add_char(hex_digit(v[15:12]));
        add_char(hex_digit(v[11:8]));
        add_char(hex_digit(v[7:4]));
        add_char(hex_digit(v[3:0]));
    endfunction

    function automatic void add_code_point(input logic [20:0] cp);
        logic [6:0]  short_esc;
        logic [20:0] off;
        short_esc = 7'h00;
        case (cp)
            21'h22: short_esc = ujs_pkg::CH_QUOTE;
            21'h5C: short_esc = ujs_pkg::CH_BSL;
            21'h08: short_esc = 7'h62;
            21'h0C: short_esc = 7'h66;
            21'h0A: short_esc = 7'h6E;
            21'h0D: short_esc = 7'h72;
            21'h09: short_esc = 7'h74;
            default: short_esc = 7'h00;
        endcase
        if (short_esc != 7'h00) begin
            add_char(ujs_pkg::CH_BSL);
            add_char(short_esc);
        end else if (cp < 21'h20) begin
            add_unit(cp[15:0]);
        end else if (cp < 21'h80) begin
            add_char(cp[6:0]);
        end else if (cp <= 21'h00FFFF) begin
            add_unit(cp[15:0]);
        end else if (cp <= ujs_pkg::CODE_MAX) begin
            off = cp - ujs_pkg::PLANE1;
            add_unit(ujs_pkg::SURR_HI + {6'd0, off[19:10]});
            add_unit(ujs_pkg::SURR_LO + {6'd0, off[9:0]});
        end else begin
            add_unit(ujs_pkg::REPL_CODE);
        end
    endfunction

    function automatic void drop_sequence();
        seq_got   = 2'd0;
        seq_len   = 3'd0;
        code_bits = 21'd0;
    endfunction

    // One replacement per byte of the abandoned sequence.
    function automatic void flush_sequence();
        for (int k = 0; k < seq_got; k++) begin
            add_unit(ujs_pkg::REPL_CODE);
        end
        drop_sequence();
    endfunction

    function automatic void escape_item(input logic act, input logic [7:0] b);
        bit lead;
        int got;
        lead = 1'b1;
        item_chars.delete();
        if (act == ujs_pkg::ACT_END) begin
            if (!str_open) begin
                add_char(ujs_pkg::CH_QUOTE);
            end else begin
                flush_sequence();
            end
            add_char(ujs_pkg::CH_QUOTE);
            str_open = 1'b0;
            drop_sequence();
        end else begin
            if (!str_open) begin
                add_char(ujs_pkg::CH_QUOTE);
                str_open = 1'b1;
            end
            if (seq_got != 2'd0) begin
                if (b[7:6] == 2'b10) begin
                    got       = seq_got + 1;
                    code_bits = {code_bits[14:0], b[5:0]};
                    lead      = 1'b0;
                    if (got >= seq_len) begin
                        add_code_point(code_bits);
                        drop_sequence();
                    end else begin
                        seq_got = got[1:0];
                    end
                end else begin
                    // The byte that broke the sequence starts over as a lead.
                    flush_sequence();
                end
            end
            if (lead) begin
                if (b < 8'h80) begin
                    add_code_point({13'd0, b});
                end else if (b[7:5] == 3'b110) begin
                    code_bits = {16'd0, b[4:0]};
                    seq_got   = 2'd1;
                    seq_len   = 3'd2;
                end else if (b[7:4] == 4'b1110) begin
                    code_bits = {17'd0, b[3:0]};
                    seq_got   = 2'd1;
                    seq_len   = 3'd3;
                end else if (b[7:3] == 5'b11110) begin
                    code_bits = {18'd0, b[2:0]};
                    seq_got   = 2'd1;
                    seq_len   = 3'd4;
                end else begin
                    add_unit(ujs_pkg::REPL_CODE);
                end
            end
        end
        for (int i = 0; i < item_chars.size(); i++) begin
            expected_chars.push_back('{ch: item_chars[i], last: (i == item_chars.size() - 1)});
        end
    endfunction

    function automatic void check_char();
        t_json_char want;
        if (expected_chars.size() == 0) begin
            $error("unexpected character %h with run_last %b", o_out_char, o_run_last);
            fail_count++;
            return;
        end
        want = expected_chars.pop_front();
        if (o_out_char !== want.ch) begin
            $error("out_char: expected %h, got %h", want.ch, o_out_char);
            fail_count++;
        end
        if (o_run_last !== want.last) begin
            $error("run_last: expected %b, got %b", want.last, o_run_last);
            fail_count++;
        end
    endfunction

    // Prediction, checking and the watchdog all sample at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_stall === 1'b0) begin
                escape_item(i_action, i_data_byte);
            end
            if (o_valid === 1'b1 && !i_stall) begin
                check_char();
            end
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("utf8_to_json_string_escaper_tb failed");
                $finish;
            end
        end
    end

    // Receiver stalls, one assignment per falling edge.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            i_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 3) == 0) begin
                stall_left <= idle_gap();
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus.
    // ---------------------------------------------------------------------
    task automatic send_item(input logic act, input logic [7:0] b);
        int gap;
        gap = quiet ? 0 : idle_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_action    <= act;
        i_data_byte <= b;
        do begin
            @(posedge i_clk);
        end while (o_stall !== 1'b0);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(ujs_pkg::ACT_DATA, b);
    endtask

    // End items carry a random, ignored byte.
    task automatic send_end();
        send_item(ujs_pkg::ACT_END, 8'($urandom));
    endtask

    // Sends the first keep bytes of a len-byte encoding of cp. A length
    // larger than needed gives an overlong form.
    task automatic send_utf8(input logic [20:0] cp, input int len, input int keep);
        logic [7:0] seq[4];
        case (len)
            1: seq[0] = {1'b0, cp[6:0]};
            2: begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3: begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default: begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++) begin
            send_byte(seq[i]);
        end
    endtask

    task automatic test_empty_string();
        send_end();
    endtask

    task automatic test_ascii_escapes();
        logic [7:0] bytes[10] = '{8'h00, 8'h22, 8'h5C, 8'h08, 8'h0C,
                                  8'h0A, 8'h0D, 8'h09, 8'h1F, 8'h7F};
        foreach (bytes[i]) begin
            send_byte(bytes[i]);
        end
    endtask

    task automatic test_multibyte();
        send_utf8(21'h0000E9, 2, 2);
        send_utf8(21'h01F600, 4, 4);   // surrogate pair
        send_utf8(21'h110000, 4, 4);   // beyond the last code point
    endtask

    task automatic test_malformed();
        send_byte(8'h80);              // stray continuation
        send_byte(8'hFF);              // invalid lead
        send_byte(8'hE2);              // broken by a plain character
        send_byte(8'h41);
        send_utf8(21'h0020AC, 3, 2);   // string ends inside a sequence
        send_end();
    endtask

    task automatic send_random_char();
        int          r;
        int          len;
        logic [20:0] cp;
        logic [7:0]  specials[10] = '{8'h00, 8'h08, 8'h09, 8'h0A, 8'h0C,
                                     8'h0D, 8'h1F, 8'h22, 8'h5C, 8'h7F};
        r = $urandom_range(0, 99);
        if (r < 40) begin
            if ($urandom_range(0, 1) == 0) begin
                send_byte(specials[$urandom_range(0, 9)]);
            end else begin
                send_byte(8'($urandom_range(0, 127)));
            end
        end else if (r < 55) begin
            send_utf8(21'($urandom_range(0, 21'h7FF)), 2, 2);
        end else if (r < 70) begin
            send_utf8(21'($urandom_range(0, 21'hFFFF)), 3, 3);
        end else if (r < 82) begin
            if ($urandom_range(0, 2) != 0) begin
                cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
            end else begin
                cp = 21'($urandom);
            end
            send_utf8(cp, 4, 4);
        end else if (r < 88) begin
            len = $urandom_range(2, 4);
            send_utf8(21'($urandom), len, $urandom_range(1, len - 1));
        end else if (r < 92) begin
            send_byte(8'($urandom_range(8'h80, 8'hBF)));
        end else if (r < 96) begin
            send_byte(8'($urandom_range(8'hF8, 8'hFF)));
        end else begin
            send_byte(8'($urandom));
        end
    endtask

    // Mostly well-formed strings with random content, some broken input.
    task automatic test_random_strings();
        int goal;
        int nchars;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal) begin
            quiet  = ($urandom_range(0, 7) == 0);
            nchars = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
            repeat (nchars) send_random_char();
            send_end();
        end
        quiet = 1'b0;
    endtask

    initial begin
        str_open = 1'b0;
        drop_sequence();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_string();
        test_ascii_escapes();
        test_multibyte();
        test_malformed();
        test_random_strings();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("utf8_to_json_string_escaper_tb passed");
        end else begin
            $display("utf8_to_json_string_escaper_tb failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/ujs_pkg.sv
hdl/ujs_front.sv
hdl/ujs_cmd_queue.sv
hdl/ujs_back.sv
hdl/utf8_to_json_string_escaper.sv
bench/utf8_to_json_string_escaper_tb.sv
